/* src/pbrle_pkg.sv */
// Shared constants and types for the PackBits run-length encoder.
package pbrle_pkg;

  // Longest literal or repeat run.
  localparam int unsigned MAX_RUN = 128;
  // Address width of the literal buffer.
  localparam int unsigned LIT_AW = $clog2(MAX_RUN);
  // Depth of the command queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  // One command from the classifier to the emitter, carried out in field order:
  // close the repeat run, push a literal byte, close the literal run, end the burst.
  typedef struct packed {
    logic       do_rep;
    logic [7:0] rep_count;
    logic [7:0] rep_val;
    logic       do_push;
    logic [7:0] push_byte;
    logic       do_close;
    logic       burst_end;
    logic       eob;
  } cmd_t;

endpackage

/* src/pbrle_cmd_fifo.sv */
// Small command queue between the classifier and the emitter.
module pbrle_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pbrle_pkg::cmd_t   push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output pbrle_pkg::cmd_t   head_o,
  output logic              empty_o
);

  pbrle_pkg::cmd_t                 slot_q [pbrle_pkg::QDEPTH];
  logic [pbrle_pkg::QAW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [pbrle_pkg::QAW:0]         cnt_q, cnt_d;

  assign full_o  = (cnt_q == (pbrle_pkg::QAW+1)'(pbrle_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage slots hold payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/pbrle_front.sv */
// Classifier: keeps the two-byte lookahead and run state and issues one command per decision.
module pbrle_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eob_i,
  output logic            cmd_valid_o,
  output pbrle_pkg::cmd_t cmd_o,
  input  logic            cmd_full_i
);

  // Lookahead and run state.
  logic [7:0] la0_q, la0_d, la1_q, la1_d;
  logic [1:0] la_n_q, la_n_d;
  logic       rep_q, rep_d;
  logic [7:0] rv_q, rv_d;
  logic [7:0] rc_q, rc_d;
  logic [7:0] lc_q, lc_d;
  logic       forced_q, forced_d;
  // Bytes to decide for the current item.
  logic       busy_q, busy_d;
  logic [7:0] dq_q [3];
  logic [7:0] dq_d [3];
  logic       dtri_q, dtri_d;
  logic [1:0] dnum_q, dnum_d, didx_q, didx_d;
  logic       eob_q, eob_d;

  logic       accept;
  logic       issue;
  logic [7:0] qb [3];
  logic [7:0] x;
  logic       tri_now;
  logic [7:0] lc_inc;
  logic [7:0] rc_inc;

  assign in_ready_o  = !busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign issue       = busy_q && !cmd_full_i;
  assign cmd_valid_o = issue;

  assign x       = dq_q[didx_q];
  assign tri_now = dtri_q && (didx_q == 2'd0);
  assign lc_inc  = lc_q + 8'd1;
  assign rc_inc  = rc_q + 8'd1;

  always_comb begin
    la0_d    = la0_q;
    la1_d    = la1_q;
    la_n_d   = la_n_q;
    rep_d    = rep_q;
    rv_d     = rv_q;
    rc_d     = rc_q;
    lc_d     = lc_q;
    forced_d = forced_q;
    busy_d   = busy_q;
    dq_d     = dq_q;
    dtri_d   = dtri_q;
    dnum_d   = dnum_q;
    didx_d   = didx_q;
    eob_d    = eob_q;
    cmd_o    = '0;
    qb[0]    = la0_q;
    qb[1]    = la1_q;
    qb[2]    = in_byte_i;

    // Take an item: line up the bytes that it decides.
    if (accept) begin
      busy_d = 1'b1;
      didx_d = 2'd0;
      eob_d  = in_eob_i;
      dtri_d = 1'b0;
      if (la_n_q == 2'd0) begin
        qb[0] = in_byte_i;
      end else if (la_n_q == 2'd1) begin
        qb[1] = in_byte_i;
      end
      dq_d[0] = qb[0];
      dq_d[1] = qb[1];
      dq_d[2] = qb[2];
      if (la_n_q == 2'd2) begin
        dtri_d = (qb[0] == qb[1]) && (qb[1] == qb[2]);
        if (in_eob_i) begin
          dnum_d = 2'd3;
          la_n_d = 2'd0;
        end else begin
          dnum_d = 2'd1;
          la0_d  = qb[1];
          la1_d  = qb[2];
        end
      end else if (in_eob_i) begin
        dnum_d = la_n_q + 2'd1;
        la_n_d = 2'd0;
      end else begin
        dnum_d = 2'd0;
        la0_d  = qb[0];
        la1_d  = qb[1];
        la_n_d = la_n_q + 2'd1;
      end
    end

    // Decide one byte, or close the item's burst.
    if (issue) begin
      if (didx_q != dnum_q) begin
        didx_d = didx_q + 2'd1;
        if (rep_q && (x == rv_q) && (rc_q < 8'(pbrle_pkg::MAX_RUN))) begin
          // The repeat run grows; it is sent when full.
          rc_d = rc_inc;
          if (rc_inc == 8'(pbrle_pkg::MAX_RUN)) begin
            cmd_o.do_rep    = 1'b1;
            cmd_o.rep_count = rc_inc;
            cmd_o.rep_val   = rv_q;
            rep_d           = 1'b0;
          end
        end else begin
          if (rep_q) begin
            cmd_o.do_rep    = 1'b1;
            cmd_o.rep_count = rc_q;
            cmd_o.rep_val   = rv_q;
            rep_d           = 1'b0;
          end
          if (forced_q || tri_now) begin
            // Open a repeat run, closing any literal first.
            cmd_o.do_close = (lc_q != 8'd0);
            lc_d           = 8'd0;
            forced_d       = 1'b0;
            rep_d          = 1'b1;
            rv_d           = x;
            rc_d           = 8'd1;
          end else begin
            cmd_o.do_push   = 1'b1;
            cmd_o.push_byte = x;
            lc_d            = lc_inc;
            if (lc_inc == 8'(pbrle_pkg::MAX_RUN)) begin
              cmd_o.do_close = 1'b1;
              lc_d           = 8'd0;
              forced_d       = 1'b1;
            end
          end
        end
      end else begin
        busy_d          = 1'b0;
        cmd_o.burst_end = 1'b1;
        cmd_o.eob       = eob_q;
        if (eob_q) begin
          cmd_o.do_rep    = rep_q;
          cmd_o.rep_count = rc_q;
          cmd_o.rep_val   = rv_q;
          cmd_o.do_close  = (lc_q != 8'd0);
          rep_d           = 1'b0;
          rc_d            = 8'd0;
          lc_d            = 8'd0;
          forced_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la0_q    <= '0;
      la1_q    <= '0;
      la_n_q   <= '0;
      rep_q    <= 1'b0;
      rv_q     <= '0;
      rc_q     <= '0;
      lc_q     <= '0;
      forced_q <= 1'b0;
      busy_q   <= 1'b0;
      dnum_q   <= '0;
      didx_q   <= '0;
      eob_q    <= 1'b0;
      dtri_q   <= 1'b0;
    end else begin
      la0_q    <= la0_d;
      la1_q    <= la1_d;
      la_n_q   <= la_n_d;
      rep_q    <= rep_d;
      rv_q     <= rv_d;
      rc_q     <= rc_d;
      lc_q     <= lc_d;
      forced_q <= forced_d;
      busy_q   <= busy_d;
      dnum_q   <= dnum_d;
      didx_q   <= didx_d;
      eob_q    <= eob_d;
      dtri_q   <= dtri_d;
    end
  end

  // Decision bytes are payload.
  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
  end

endmodule

/* src/pbrle_back.sv */
// Emitter: carries out commands, holds the literal buffer and packs code bytes into words.
module pbrle_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_empty_i,
  input  pbrle_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     out_bytes_o,
  output logic [3:0]      out_count_o,
  output logic            out_last_o,
  output logic            out_done_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REPH = 3'd1;
  localparam logic [2:0] S_REPV = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_LITH = 3'd4;
  localparam logic [2:0] S_LITB = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  logic [2:0]                  st_q, st_d;
  pbrle_pkg::cmd_t             cmd_q, cmd_d;
  logic [7:0]                  bcnt_q, bcnt_d;
  logic [pbrle_pkg::LIT_AW-1:0] lidx_q, lidx_d, rd_addr;
  logic [7:0]                  mem [pbrle_pkg::MAX_RUN];
  logic [7:0]                  rdata_q;
  logic                        mem_we;

  logic [63:0] acc_q, acc_d;
  logic [3:0]  acc_cnt_q, acc_cnt_d;
  logic        ov_q, ov_d;
  logic [63:0] ob_q, ob_d;
  logic [3:0]  oc_q, oc_d;
  logic        ol_q, ol_d, od_q, od_d;

  logic        out_free, pk_ready, bw_en;
  logic [7:0]  bw_byte;
  logic [2:0]  after_rep, after_push;

  assign out_free   = !ov_q || out_ready_i;
  assign pk_ready   = (acc_cnt_q != 4'd8) || out_free;
  assign after_push = cmd_q.do_close ? S_LITH : S_END;
  assign after_rep  = cmd_q.do_push ? S_PUSH : after_push;
  assign mem_we     = (st_q == S_PUSH);
  assign cmd_pop_o  = (st_q == S_IDLE) && !cmd_empty_i;

  // Byte offered to the packer in each state.
  always_comb begin
    bw_en   = 1'b0;
    bw_byte = '0;
    unique case (st_q)
      S_REPH: begin
        bw_en   = 1'b1;
        bw_byte = 8'd1 - cmd_q.rep_count;
      end
      S_REPV: begin
        bw_en   = 1'b1;
        bw_byte = cmd_q.rep_val;
      end
      S_LITH: begin
        bw_en   = 1'b1;
        bw_byte = bcnt_q - 8'd1;
      end
      S_LITB: begin
        bw_en   = 1'b1;
        bw_byte = rdata_q;
      end
      default: begin
        bw_en   = 1'b0;
        bw_byte = '0;
      end
    endcase
  end

  // Command sequencer.
  always_comb begin
    st_d    = st_q;
    cmd_d   = cmd_q;
    bcnt_d  = bcnt_q;
    lidx_d  = lidx_q;
    rd_addr = '0;
    unique case (st_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_d = cmd_i;
          if (cmd_i.do_rep) begin
            st_d = S_REPH;
          end else if (cmd_i.do_push) begin
            st_d = S_PUSH;
          end else if (cmd_i.do_close) begin
            st_d = S_LITH;
          end else if (cmd_i.burst_end) begin
            st_d = S_END;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_REPH: begin
        if (pk_ready) begin
          st_d = S_REPV;
        end
      end
      S_REPV: begin
        if (pk_ready) begin
          st_d = after_rep;
        end
      end
      S_PUSH: begin
        bcnt_d = bcnt_q + 8'd1;
        st_d   = after_push;
      end
      S_LITH: begin
        lidx_d = '0;
        if (pk_ready) begin
          st_d = S_LITB;
        end
      end
      S_LITB: begin
        rd_addr = lidx_q;
        if (pk_ready) begin
          rd_addr = lidx_q + 1'b1;
          lidx_d  = lidx_q + 1'b1;
          if ({1'b0, lidx_q} + 8'd1 == bcnt_q) begin
            bcnt_d = 8'd0;
            st_d   = S_END;
          end
        end
      end
      S_END: begin
        if (!cmd_q.burst_end) begin
          st_d = S_IDLE;
        end else if ((acc_cnt_q == 4'd0) || out_free) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Packer and output register.
  always_comb begin
    acc_d     = acc_q;
    acc_cnt_d = acc_cnt_q;
    ov_d      = ov_q && !out_ready_i;
    ob_d      = ob_q;
    oc_d      = oc_q;
    ol_d      = ol_q;
    od_d      = od_q;
    if (bw_en && pk_ready) begin
      if (acc_cnt_q == 4'd8) begin
        ov_d      = 1'b1;
        ob_d      = acc_q;
        oc_d      = acc_cnt_q;
        ol_d      = 1'b0;
        od_d      = 1'b0;
        acc_d     = {56'd0, bw_byte};
        acc_cnt_d = 4'd1;
      end else begin
        acc_d[{acc_cnt_q[2:0], 3'b000} +: 8] = bw_byte;
        acc_cnt_d = acc_cnt_q + 4'd1;
      end
    end else if ((st_q == S_END) && cmd_q.burst_end && (acc_cnt_q != 4'd0) && out_free) begin
      ov_d      = 1'b1;
      ob_d      = acc_q;
      oc_d      = acc_cnt_q;
      ol_d      = 1'b1;
      od_d      = cmd_q.eob;
      acc_d     = '0;
      acc_cnt_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      bcnt_q    <= '0;
      lidx_q    <= '0;
      acc_q     <= '0;
      acc_cnt_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      st_q      <= st_d;
      bcnt_q    <= bcnt_d;
      lidx_q    <= lidx_d;
      acc_q     <= acc_d;
      acc_cnt_q <= acc_cnt_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    ob_q  <= ob_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
    od_q  <= od_d;
  end

  // Literal buffer with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[bcnt_q[pbrle_pkg::LIT_AW-1:0]] <= cmd_q.push_byte;
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o = ov_q;
  assign out_bytes_o = ob_q;
  assign out_count_o = oc_q;
  assign out_last_o  = ol_q;
  assign out_done_o  = od_q;

  // The literal count never exceeds the longest run.
  a_bcnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= 8'(pbrle_pkg::MAX_RUN))
    else $error("literal count out of range");

  // A literal is only sent while bytes are held.
  a_lit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_LITH || st_q == S_LITB) |-> bcnt_q != 8'd0)
    else $error("empty literal sent");

  // A word leaves with at least one byte.
  a_word_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oc_q != 4'd0 && oc_q <= 4'd8))
    else $error("bad byte count on output word");

  // The done flag only comes with the last word of a burst.
  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q) |-> ol_q)
    else $error("block done without burst end");

endmodule

/* src/packbits_run_length_encoder.sv */
// Top level of the PackBits run-length encoder.
// An item is held while the classifier issues one command per byte it decides and a closing command,
// so the input takes no new item until then; a full command queue stalls it.
// The emitter fetches each command, sends code bytes, stores literal pushes and wraps up in turn;
// a closing literal sends its header byte and then its stored bytes, and a full output stalls it.
// Reset is asynchronous and clears all run state; the literal buffer needs no clearing.
module packbits_run_length_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_block
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] code_bytes, [67:64] byte_count, zero pad
  output logic        m_axis_tlast_o,   // block_done
  output logic [0:0]  m_axis_tuser_o    // [0] last_of_burst
);

  pbrle_pkg::cmd_t cmd_in, cmd_head;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [63:0]     out_bytes;
  logic [3:0]      out_count;
  logic            out_last;

  pbrle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_eob_i    (s_axis_tlast_i),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  pbrle_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_in),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .head_o     (cmd_head),
    .empty_o    (cmd_empty)
  );

  pbrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_bytes_o (out_bytes),
    .out_count_o (out_count),
    .out_last_o  (out_last),
    .out_done_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_count, out_bytes};
  assign m_axis_tuser_o = out_last;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the PackBits run-length encoder.
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] data_byte
  logic        s_axis_tlast_i;   // end_of_block
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;   // [63:0] code_bytes, [67:64] byte_count, zero pad
  logic        m_axis_tlast_o;   // block_done
  logic [0:0]  m_axis_tuser_o;   // [0] last_of_burst

  localparam int unsigned RUN_LIMIT = pbrle_pkg::MAX_RUN;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One expected result word.
  typedef struct {
    logic [63:0] code_bytes;
    logic [3:0]  byte_count;
    logic        last_of_burst;
    logic        block_done;
  } code_word_t;

  packbits_run_length_encoder DUT (.*);

  // Encoder state held by the predictor.
  logic [7:0] lit_buf [RUN_LIMIT];
  int unsigned lit_len;
  logic [7:0] pend [2];
  int unsigned pend_len;
  logic [7:0] rep_byte;
  int unsigned rep_len;
  bit rep_open;
  bit force_rep;
  logic [7:0] burst_bytes [$];
  code_word_t expected_words [$];

  bit failed;
  bit sink_stall_enable;
  bit long_hold;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-closing helpers of the predictor.
  task automatic flush_literal();
    if (lit_len == 0) return;
    burst_bytes.push_back(8'(lit_len - 1));
    for (int i = 0; i < lit_len; i++) burst_bytes.push_back(lit_buf[i]);
    lit_len = 0;
  endtask

  task automatic flush_repeat();
    if (!rep_open) return;
    burst_bytes.push_back(8'(0 - (rep_len - 1)));
    burst_bytes.push_back(rep_byte);
    rep_open = 1'b0;
    rep_len = 0;
  endtask

  // Settles one source byte; triple says it and the next two are equal.
  task automatic settle_byte(input logic [7:0] b, input bit triple);
    if (rep_open) begin
      if (b == rep_byte && rep_len < RUN_LIMIT) begin
        rep_len++;
        if (rep_len >= RUN_LIMIT) flush_repeat();
        return;
      end
      flush_repeat();
    end
    if (force_rep || triple) begin
      flush_literal();
      force_rep = 1'b0;
      rep_open = 1'b1;
      rep_byte = b;
      rep_len = 1;
      return;
    end
    lit_buf[lit_len] = b;
    lit_len++;
    if (lit_len >= RUN_LIMIT) begin
      flush_literal();
      force_rep = 1'b1;
    end
  endtask

  // Predicts the code words caused by one source byte.
  task automatic predict_code(input logic [7:0] b, input bit eob);
    logic [7:0] q [3];
    int unsigned n;
    int unsigned nw;
    code_word_t w;
    q[0] = pend[0];
    q[1] = pend[1];
    n = pend_len;
    q[n] = b;
    n++;
    if (n == 3) begin
      settle_byte(q[0], q[0] == q[1] && q[1] == q[2]);
      q[0] = q[1];
      q[1] = q[2];
      n = 2;
    end
    if (eob) begin
      for (int i = 0; i < n; i++) settle_byte(q[i], 1'b0);
      n = 0;
      flush_repeat();
      flush_literal();
      force_rep = 1'b0;
    end
    pend_len = n;
    pend[0] = q[0];
    pend[1] = q[1];
    nw = (burst_bytes.size() + 7) / 8;
    for (int k = 0; k < nw; k++) begin
      w.code_bytes = '0;
      w.byte_count = '0;
      for (int i = 0; i < 8 && burst_bytes.size() > 0; i++) begin
        w.code_bytes[8*i +: 8] = burst_bytes.pop_front();
        w.byte_count++;
      end
      w.last_of_burst = (k == nw - 1);
      w.block_done = eob && (k == nw - 1);
      expected_words.push_back(w);
    end
  endtask

  // Offers one byte, with random idling first, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b, input bit eob, input bit idle);
    if (idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= eob;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_code(b, eob);
  endtask

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (sink_stall_enable && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Compares every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    code_word_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata_o);
        failed = 1'b1;
      end else begin
        e = expected_words.pop_front();
        if (m_axis_tdata_o[63:0] !== e.code_bytes || m_axis_tdata_o[67:64] !== e.byte_count
            || m_axis_tuser_o[0] !== e.last_of_burst || m_axis_tlast_o !== e.block_done) begin
          $display("%0t: expected %h cnt %0d lob %b done %b, actual %h cnt %0d lob %b done %b",
                   $time, e.code_bytes, e.byte_count, e.last_of_burst, e.block_done,
                   m_axis_tdata_o[63:0], m_axis_tdata_o[67:64], m_axis_tuser_o[0],
                   m_axis_tlast_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Short blocks, the extremes of the byte range and a lone byte.
  task automatic test_short_blocks();
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'haa, 1'b1, 1'b1);
    send_byte(8'h07, 1'b0, 1'b1);
    send_byte(8'h07, 1'b0, 1'b1);
    send_byte(8'h07, 1'b1, 1'b1);
  endtask

  // Full repeat and full literal runs, including the forced repeat that follows.
  task automatic test_full_runs();
    for (int i = 0; i < 130; i++) send_byte(8'h3c, 1'b0, 1'b1);
    for (int i = 0; i < 129; i++) send_byte(8'(i * 2 + 1), 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);
  endtask

  // Random blocks mixing runs and noise.
  task automatic test_random_blocks(input int unsigned n_bytes, input bit idle);
    int unsigned left;
    int unsigned run;
    logic [7:0] b;
    left = n_bytes;
    while (left > 0) begin
      run = $urandom_range(0, 2) == 0 ? $urandom_range(1, 140) : $urandom_range(1, 3);
      if (run > left) run = left;
      b = 8'($urandom);
      for (int i = 0; i < run; i++) begin
        left--;
        send_byte(b, left == 0 || $urandom_range(0, 40) == 0, idle);
      end
    end
  endtask

  // Receiver holds off while bytes keep coming, so the input stalls.
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 3)), i == 39, 1'b0);
  endtask

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tlast_i <= 1'b0;
    sink_stall_enable = 1'b1;
    long_hold = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_blocks();
    test_full_runs();
    test_backpressure();
    test_random_blocks(40, 1'b1);
    sink_stall_enable = 1'b0;
    test_random_blocks(12, 1'b0);
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pbrle_pkg.sv
src/pbrle_cmd_fifo.sv
src/pbrle_front.sv
src/pbrle_back.sv
src/packbits_run_length_encoder.sv
test/testbench.sv
